### hdl/vted_pkg.sv
// Package: shared types, codes and lookup functions for the VT escape input decoder.
`timescale 1ns / 1ps
package vted_pkg;

    localparam int VALUE_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_GROUND = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_SS3    = 2'd2,
        MODE_CSI    = 2'd3
    } mode_t;

    localparam logic [2:0] EV_KEY        = 3'd0;
    localparam logic [2:0] EV_CHAR       = 3'd1;
    localparam logic [2:0] EV_MOUSE      = 3'd2;
    localparam logic [2:0] EV_PASTE_CHAR = 3'd3;
    localparam logic [2:0] EV_PASTE_END  = 3'd4;

    localparam logic [4:0] KEY_NONE  = 5'd0;
    localparam logic [4:0] KEY_ENTER = 5'd1;
    localparam logic [4:0] KEY_TAB   = 5'd2;
    localparam logic [4:0] KEY_BKSP  = 5'd3;
    localparam logic [4:0] KEY_ESC   = 5'd4;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [4:0]  key_id;
        logic [20:0] char_out;
        logic [2:0]  modifiers;
        logic [2:0]  mouse_button;
        logic [1:0]  mouse_action;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } result_t;

    function automatic logic [4:0] letter_key(input logic [20:0] ch);
        logic [4:0] k;
        begin
            unique case (ch)
                21'h41:  k = 5'd5;
                21'h42:  k = 5'd6;
                21'h43:  k = 5'd7;
                21'h44:  k = 5'd8;
                21'h48:  k = 5'd9;
                21'h46:  k = 5'd10;
                21'h50:  k = 5'd15;
                21'h51:  k = 5'd16;
                21'h52:  k = 5'd17;
                21'h53:  k = 5'd18;
                default: k = KEY_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] tilde_key(input logic [4:0] p, input logic big);
        logic [4:0] k;
        begin
            if (big)
                k = KEY_NONE;
            else
            begin
                unique case (p)
                    5'd1, 5'd7: k = 5'd9;
                    5'd2:       k = 5'd11;
                    5'd3:       k = 5'd12;
                    5'd4, 5'd8: k = 5'd10;
                    5'd5:       k = 5'd13;
                    5'd6:       k = 5'd14;
                    5'd11:      k = 5'd15;
                    5'd12:      k = 5'd16;
                    5'd13:      k = 5'd17;
                    5'd14:      k = 5'd18;
                    5'd15:      k = 5'd19;
                    5'd17:      k = 5'd20;
                    5'd18:      k = 5'd21;
                    5'd19:      k = 5'd22;
                    5'd20:      k = 5'd23;
                    5'd21:      k = 5'd24;
                    5'd23:      k = 5'd25;
                    5'd24:      k = 5'd26;
                    default:    k = KEY_NONE;
                endcase
            end
            return k;
        end
    endfunction

endpackage

### hdl/vt_escape_input_decoder_core.sv
// Top level: VT/ANSI keyboard and mouse input decoder with stream ports.
// channel | dir | tdata (low bit up)                                       | tuser
// s_axis  | in  | code_point[20:0], base_modifiers[23:21]                    | cmd
// m_axis  | out | kind[2:0] key[7:3] char[28:8] mods[31:29] btn[34:32]
//         |     | act[36:35] x[52:37] y[68:53], zero pad to 72              | -
// One codepoint per cycle while the input is ready; each result is registered in the output stage.
// Parser state is registered from a combinational decode of the unregistered input.
// Reset clears parser state and output valids asynchronously.
// A stalled output holds two results; the input stalls only once both are full.
`timescale 1ns / 1ps
module vt_escape_input_decoder_core #(
    parameter int VALUE_BITS = vted_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // code_point, base_modifiers
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // event_kind,key_id,char_out,modifiers,button,action,x,y
);
    logic step, res_valid;
    vted_pkg::result_t res, od;

    assign step = s_axis_tvalid && s_axis_tready;

    vted_decode #(.VALUE_BITS(VALUE_BITS)) u_dec (
        .clk(clk), .rst_n(rst_n), .step(step), .cmd(s_axis_tuser),
        .code_point(s_axis_tdata[20:0]), .base_modifiers(s_axis_tdata[23:21]),
        .res_valid(res_valid), .res(res)
    );

    vted_out_skid u_out (
        .clk(clk), .rst_n(rst_n), .in_valid(step && res_valid), .in_ready(s_axis_tready),
        .in_data(res), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(od)
    );

    assign m_axis_tdata = {3'd0, od.pos_y, od.pos_x, od.mouse_action, od.mouse_button,
                           od.modifiers, od.char_out, od.key_id, od.event_kind};
endmodule

### hdl/vted_decode.sv
// Decoder: parser state registers and next-state/result logic for one codepoint per cycle, advancing only on step.
`timescale 1ns / 1ps
module vted_decode #(
    parameter int VALUE_BITS = vted_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               cmd,
    input  logic [20:0]        code_point,
    input  logic [2:0]         base_modifiers,
    output logic               res_valid,
    output vted_pkg::result_t  res
);
    localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

    vted_pkg::mode_t mode_reg, mode_next;
    logic [2:0] escm_reg, escm_next;
    logic sgr_reg, sgr_next, paste_reg, paste_next;
    logic [1:0] fc_reg, fc_next;
    logic [VALUE_BITS-1:0] cur_reg, cur_next, s0_reg, s0_next, s1_reg, s1_next;
    logic [2:0] dc_reg, dc_next;

    logic [VALUE_BITS+3:0] mul;
    logic [VALUE_BITS-1:0] sat, ff, kmv, xv, yv, b;
    logic [2:0] km, mm;
    logic [4:0] k;
    logic is_digit;
    logic [20:0] ch, gch;
    logic [2:0] gmods;
    logic clr, tog;
    logic [1:0] bb;

    assign ch = code_point;
    assign is_digit = (ch >= 21'h30) && (ch <= 21'h39);
    assign mul = {4'd0, cur_reg} * (VALUE_BITS+4)'(10) + (VALUE_BITS+4)'(ch[3:0]);
    assign sat = (mul > {4'd0, VMAX}) ? VMAX : mul[VALUE_BITS-1:0];
    assign ff  = (fc_reg != 2'd0) ? s0_reg : cur_reg;
    assign kmv = (fc_reg == 2'd1) ? cur_reg : s1_reg;
    assign km  = (fc_reg == 2'd0 || kmv <= 1) ? 3'd0 : 3'(kmv - 1'b1);
    assign b   = s0_reg;
    assign xv  = (s1_reg != 0) ? s1_reg - 1'b1 : '0;
    assign yv  = (cur_reg != 0) ? cur_reg - 1'b1 : '0;
    assign mm  = 3'(b >> 2);
    assign bb  = b[1:0];
    assign gmods = (mode_reg == vted_pkg::MODE_ESC) ? (escm_reg | 3'b010) : base_modifiers;

    always_comb
    begin
        mode_next = mode_reg; escm_next = escm_reg; sgr_next = sgr_reg;
        paste_next = paste_reg; fc_next = fc_reg; cur_next = cur_reg;
        dc_next = dc_reg; s0_next = s0_reg; s1_next = s1_reg;
        res_valid = 1'b0; res = '0; clr = 1'b0; tog = 1'b0; k = vted_pkg::KEY_NONE;
        gch = '0;
        if (cmd)
        begin
            if (mode_reg == vted_pkg::MODE_ESC)
            begin
                tog = 1'b1; res_valid = 1'b1;
                res.event_kind = vted_pkg::EV_KEY; res.key_id = vted_pkg::KEY_ESC;
                res.modifiers = escm_reg;
            end
        end
        else if (paste_reg && mode_reg == vted_pkg::MODE_GROUND && ch != 21'h1B)
        begin
            res_valid = 1'b1; res.event_kind = vted_pkg::EV_PASTE_CHAR; res.char_out = ch;
        end
        else if (mode_reg == vted_pkg::MODE_ESC && ch == 21'h5B)
        begin
            mode_next = vted_pkg::MODE_CSI; clr = 1'b1;
        end
        else if (mode_reg == vted_pkg::MODE_ESC && ch == 21'h4F)
            mode_next = vted_pkg::MODE_SS3;
        else if (mode_reg == vted_pkg::MODE_GROUND || mode_reg == vted_pkg::MODE_ESC)
        begin
            mode_next = vted_pkg::MODE_GROUND;
            if (ch == 21'h1B)
            begin
                mode_next = vted_pkg::MODE_ESC; escm_next = gmods;
            end
            else
            begin
                res_valid = 1'b1; res.modifiers = gmods; res.event_kind = vted_pkg::EV_KEY;
                if (ch == 21'h0D || ch == 21'h0A) res.key_id = vted_pkg::KEY_ENTER;
                else if (ch == 21'h09) res.key_id = vted_pkg::KEY_TAB;
                else if (ch == 21'h08 || ch == 21'h7F) res.key_id = vted_pkg::KEY_BKSP;
                else
                begin
                    res.event_kind = vted_pkg::EV_CHAR;
                    if (ch < 21'h20)
                    begin
                        res.modifiers = gmods | 3'b100;
                        if (ch == 21'h00) gch = 21'h20;
                        else if (ch >= 21'h1C) gch = ch + 21'h40;
                        else gch = ch + 21'h60;
                        res.char_out = gch;
                    end
                    else res.char_out = ch;
                end
            end
        end
        else if (mode_reg == vted_pkg::MODE_SS3)
        begin
            mode_next = vted_pkg::MODE_GROUND;
            k = vted_pkg::letter_key(ch);
            res_valid = (k != vted_pkg::KEY_NONE);
            res.event_kind = vted_pkg::EV_KEY; res.key_id = k;
        end
        else
        begin
            if (sgr_reg && (ch == 21'h4D || ch == 21'h6D))
            begin
                tog = 1'b1;
                if (fc_reg >= 2'd2)
                begin
                    res_valid = 1'b1; res.event_kind = vted_pkg::EV_MOUSE;
                    res.modifiers = mm; res.mouse_action = 2'd3;
                    res.pos_x = 16'(xv); res.pos_y = 16'(yv);
                    if (b == 64) res.mouse_button = 3'd3;
                    else if (b == 65) res.mouse_button = 3'd4;
                    else
                    begin
                        res.mouse_button = (bb == 2'd1) ? 3'd1 : (bb == 2'd2) ? 3'd2 : 3'd0;
                        if (b[5]) res.mouse_action = 2'd2;
                        else if (ch == 21'h6D || bb == 2'd3) res.mouse_action = 2'd1;
                        else res.mouse_action = 2'd0;
                    end
                end
            end
            else if (!sgr_reg && ch == 21'h3C)
            begin
                sgr_next = 1'b1; clr = 1'b1;
            end
            else if (is_digit)
            begin
                if (fc_reg != 2'd3)
                begin
                    cur_next = sat;
                    if (dc_reg != 3'd7) dc_next = dc_reg + 3'd1;
                end
            end
            else if (ch == 21'h3B)
            begin
                if (fc_reg == 2'd2) fc_next = 2'd3;
                else if (fc_reg != 2'd3)
                begin
                    if (fc_reg == 2'd0) s0_next = cur_reg; else s1_next = cur_reg;
                    fc_next = fc_reg + 2'd1; cur_next = '0; dc_next = '0;
                end
            end
            else
            begin
                tog = 1'b1;
                if (!sgr_reg)
                begin
                    res.event_kind = vted_pkg::EV_KEY; res.modifiers = km;
                    if (ch == 21'h7E)
                    begin
                        if (fc_reg == 2'd0 && dc_reg == 3'd3 && cur_reg == 200)
                            paste_next = 1'b1;
                        else if (fc_reg == 2'd0 && dc_reg == 3'd3 && cur_reg == 201)
                        begin
                            paste_next = 1'b0; res_valid = 1'b1;
                            res.event_kind = vted_pkg::EV_PASTE_END; res.modifiers = '0;
                        end
                        else
                        begin
                            k = vted_pkg::tilde_key(ff[4:0], (ff >> 5) != 0);
                            res_valid = (k != vted_pkg::KEY_NONE); res.key_id = k;
                        end
                    end
                    else
                    begin
                        k = vted_pkg::letter_key(ch);
                        res_valid = (k != vted_pkg::KEY_NONE); res.key_id = k;
                    end
                end
            end
        end
        if (tog)
        begin
            mode_next = vted_pkg::MODE_GROUND; sgr_next = 1'b0; clr = 1'b1;
        end
        if (clr)
        begin
            fc_next = '0; cur_next = '0; dc_next = '0; s0_next = '0; s1_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= vted_pkg::MODE_GROUND; escm_reg <= '0; sgr_reg <= 1'b0;
            paste_reg <= 1'b0; fc_reg <= '0; cur_reg <= '0; dc_reg <= '0;
            s0_reg <= '0; s1_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next; escm_reg <= escm_next; sgr_reg <= sgr_next;
            paste_reg <= paste_next; fc_reg <= fc_next; cur_reg <= cur_next;
            dc_reg <= dc_next; s0_reg <= s0_next; s1_reg <= s1_next;
        end
    end
endmodule

### hdl/vted_out_skid.sv
// Output stage: result register with a skid entry so the input side waits on a stall only once the skid entry is full.
`timescale 1ns / 1ps
module vted_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vted_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output vted_pkg::result_t out_data
);
    logic main_v_reg, skid_v_reg;
    vted_pkg::result_t main_reg, skid_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0; skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || out_ready)
            begin
                if (skid_v_reg)
                begin
                    main_v_reg <= 1'b1; skid_v_reg <= 1'b0;
                end
                else main_v_reg <= in_valid;
            end
            else if (in_valid && !skid_v_reg) skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || out_ready)
            main_reg <= skid_v_reg ? skid_reg : in_data;
        if (in_valid && !skid_v_reg) skid_reg <= in_data;
    end
endmodule

### hdl/vted_checker.sv
// Checker: port-level assertions for the decoder, bound to the top level.
`timescale 1ns / 1ps
module vted_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("bad event kind");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:69] == 3'd0)
        else $error("pad bits set");
endmodule

bind vt_escape_input_decoder_core vted_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

### dv/vt_escape_input_decoder_core_tb.sv
// Testbench: directed and randomised stream check of the VT escape input decoder against an internal predictor.
`timescale 1ns / 1ps
module vt_escape_input_decoder_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // code_point[20:0], base_modifiers[23:21]
    logic        s_axis_tuser;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;  // kind, key, char, mods, btn, act, x, y

    typedef struct packed {
        logic        flush;
        logic [20:0] cp;
        logic [2:0]  mods;
    } key_in_t;

    vt_escape_input_decoder_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    key_in_t            pending_keys[$];
    vted_pkg::result_t  expected_events[$];
    int      errors;
    int      mismatches;
    int      idle_cycles;
    bit      stim_done;
    int      tx_gap;
    int      rx_gap;

    // decoder state copy
    vted_pkg::mode_t p_mode;
    logic [2:0]  p_esc_mods;
    logic        p_mouse;
    logic        p_paste;
    logic [1:0]  p_nfields;
    logic [15:0] p_value;
    logic [2:0]  p_ndigits;
    logic [15:0] p_saved[2];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic vted_pkg::result_t mk_event(logic [2:0] kind, logic [4:0] key,
                                                   logic [20:0] ch, logic [2:0] mods);
        vted_pkg::result_t r;
        r = '0;
        r.event_kind = kind;
        r.key_id     = key;
        r.char_out   = ch;
        r.modifiers  = mods;
        return r;
    endfunction

    function automatic logic [4:0] lookup_letter(logic [20:0] ch);
        case (ch)
            "A": return 5'd5;
            "B": return 5'd6;
            "C": return 5'd7;
            "D": return 5'd8;
            "H": return 5'd9;
            "F": return 5'd10;
            "P": return 5'd15;
            "Q": return 5'd16;
            "R": return 5'd17;
            "S": return 5'd18;
            default: return vted_pkg::KEY_NONE;
        endcase
    endfunction

    function automatic logic [4:0] lookup_tilde(logic [15:0] p);
        case (p)
            1, 7:  return 5'd9;
            2:     return 5'd11;
            3:     return 5'd12;
            4, 8:  return 5'd10;
            5:     return 5'd13;
            6:     return 5'd14;
            11:    return 5'd15;
            12:    return 5'd16;
            13:    return 5'd17;
            14:    return 5'd18;
            15:    return 5'd19;
            17:    return 5'd20;
            18:    return 5'd21;
            19:    return 5'd22;
            20:    return 5'd23;
            21:    return 5'd24;
            23:    return 5'd25;
            24:    return 5'd26;
            default: return vted_pkg::KEY_NONE;
        endcase
    endfunction

    function automatic logic [2:0] vt_mod_bits(logic [15:0] v);
        logic [15:0] t;
        t = v - 16'd1;
        return (v <= 16'd1) ? 3'd0 : t[2:0];
    endfunction

    function automatic void clear_fields();
        p_nfields = 2'd0;
        p_value   = '0;
        p_ndigits = 3'd0;
        p_saved[0] = '0;
        p_saved[1] = '0;
    endfunction

    function automatic void back_to_ground();
        p_mode  = vted_pkg::MODE_GROUND;
        p_mouse = 1'b0;
        clear_fields();
    endfunction

    function automatic void add_digit(logic [3:0] d);
        logic [31:0] v;
        if (p_nfields != 2'd3)
        begin
            v = p_value * 32'd10 + 32'(d);
            p_value = (v > 32'(FIELD_MAX)) ? FIELD_MAX : v[15:0];
            if (p_ndigits < 3'd7)
                p_ndigits = p_ndigits + 3'd1;
        end
    endfunction

    function automatic void add_separator();
        if (p_nfields == 2'd2)
            p_nfields = 2'd3;
        else if (p_nfields < 2'd2)
        begin
            p_saved[p_nfields[0]] = p_value;
            p_nfields = p_nfields + 2'd1;
            p_value   = '0;
            p_ndigits = 3'd0;
        end
    endfunction

    function automatic bit decode_ground(logic [20:0] ch, logic [2:0] mods,
                                         output vted_pkg::result_t r);
        logic [20:0] base;
        r = '0;
        if (ch == 21'h1B)
        begin
            p_mode = vted_pkg::MODE_ESC;
            p_esc_mods = mods;
            return 0;
        end
        if (ch == 21'h0D || ch == 21'h0A)
            r = mk_event(vted_pkg::EV_KEY, vted_pkg::KEY_ENTER, '0, mods);
        else if (ch == 21'h09)
            r = mk_event(vted_pkg::EV_KEY, vted_pkg::KEY_TAB, '0, mods);
        else if (ch == 21'h08 || ch == 21'h7F)
            r = mk_event(vted_pkg::EV_KEY, vted_pkg::KEY_BKSP, '0, mods);
        else if (ch < 21'h20)
        begin
            case (ch)
                21'h00:  base = 21'h20;
                21'h1C:  base = 21'h5C;
                21'h1D:  base = 21'h5D;
                21'h1E:  base = 21'h5E;
                21'h1F:  base = 21'h5F;
                default: base = 21'h61 + ch - 21'h1;
            endcase
            r = mk_event(vted_pkg::EV_CHAR, vted_pkg::KEY_NONE, base, mods | 3'd4);
        end
        else
            r = mk_event(vted_pkg::EV_CHAR, vted_pkg::KEY_NONE, ch, mods);
        return 1;
    endfunction

    function automatic bit decode_csi(logic [20:0] ch, output vted_pkg::result_t r);
        bit          is_digit;
        logic [15:0] b;
        logic [1:0]  btn;
        logic [4:0]  key;
        logic [2:0]  kmods;
        bit          hit;
        r = '0;
        hit = 0;
        is_digit = (ch >= "0" && ch <= "9");
        if (p_mouse)
        begin
            if (ch == "M" || ch == "m")
            begin
                if (p_nfields >= 2'd2)
                begin
                    b = p_saved[0];
                    r.event_kind = vted_pkg::EV_MOUSE;
                    r.modifiers  = b[4:2];
                    r.pos_x = (p_saved[1] > 0) ? p_saved[1] - 16'd1 : 16'd0;
                    r.pos_y = (p_value > 0) ? p_value - 16'd1 : 16'd0;
                    if (b == 16'd64 || b == 16'd65)
                    begin
                        r.mouse_button = (b == 16'd64) ? 3'd3 : 3'd4;
                        r.mouse_action = 2'd3;
                    end
                    else
                    begin
                        btn = b[1:0];
                        r.mouse_button = (btn == 2'd1) ? 3'd1 : (btn == 2'd2) ? 3'd2 : 3'd0;
                        if (b[5])
                            r.mouse_action = 2'd2;
                        else if (ch == "m" || btn == 2'd3)
                            r.mouse_action = 2'd1;
                        else
                            r.mouse_action = 2'd0;
                    end
                    hit = 1;
                end
                back_to_ground();
            end
            else if (is_digit)
                add_digit(ch[3:0]);
            else if (ch == ";")
                add_separator();
            else
                back_to_ground();
            return hit;
        end
        if (ch == "<")
        begin
            p_mouse = 1'b1;
            clear_fields();
            return 0;
        end
        if (is_digit)
        begin
            add_digit(ch[3:0]);
            return 0;
        end
        if (ch == ";")
        begin
            add_separator();
            return 0;
        end
        kmods = (p_nfields == 2'd0) ? 3'd0
              : vt_mod_bits((p_nfields == 2'd1) ? p_value : p_saved[1]);
        if (ch == "~")
        begin
            if (p_nfields == 2'd0 && p_ndigits == 3'd3 && p_value == 16'd200)
                p_paste = 1'b1;
            else if (p_nfields == 2'd0 && p_ndigits == 3'd3 && p_value == 16'd201)
            begin
                p_paste = 1'b0;
                r = mk_event(vted_pkg::EV_PASTE_END, vted_pkg::KEY_NONE, '0, 3'd0);
                hit = 1;
            end
            else
            begin
                key = lookup_tilde((p_nfields >= 2'd1) ? p_saved[0] : p_value);
                if (key != vted_pkg::KEY_NONE)
                begin
                    r = mk_event(vted_pkg::EV_KEY, key, '0, kmods);
                    hit = 1;
                end
            end
        end
        else
        begin
            key = lookup_letter(ch);
            if (key != vted_pkg::KEY_NONE)
            begin
                r = mk_event(vted_pkg::EV_KEY, key, '0, kmods);
                hit = 1;
            end
        end
        back_to_ground();
        return hit;
    endfunction

    function automatic bit predict_event(key_in_t in, output vted_pkg::result_t r);
        logic [4:0] key;
        r = '0;
        if (in.flush)
        begin
            if (p_mode == vted_pkg::MODE_ESC)
            begin
                back_to_ground();
                r = mk_event(vted_pkg::EV_KEY, vted_pkg::KEY_ESC, '0, p_esc_mods);
                return 1;
            end
            return 0;
        end
        if (p_paste && p_mode == vted_pkg::MODE_GROUND && in.cp != 21'h1B)
        begin
            r = mk_event(vted_pkg::EV_PASTE_CHAR, vted_pkg::KEY_NONE, in.cp, 3'd0);
            return 1;
        end
        case (p_mode)
            vted_pkg::MODE_GROUND: return decode_ground(in.cp, in.mods, r);
            vted_pkg::MODE_ESC:
            begin
                if (in.cp == "[")
                begin
                    p_mode = vted_pkg::MODE_CSI;
                    clear_fields();
                    return 0;
                end
                if (in.cp == "O")
                begin
                    p_mode = vted_pkg::MODE_SS3;
                    return 0;
                end
                p_mode = vted_pkg::MODE_GROUND;
                return decode_ground(in.cp, p_esc_mods | 3'd2, r);
            end
            vted_pkg::MODE_SS3:
            begin
                p_mode = vted_pkg::MODE_GROUND;
                key = lookup_letter(in.cp);
                if (key != vted_pkg::KEY_NONE)
                    r = mk_event(vted_pkg::EV_KEY, key, '0, 3'd0);
                return key != vted_pkg::KEY_NONE;
            end
            default: return decode_csi(in.cp, r);
        endcase
    endfunction

    task automatic push_cp(logic [20:0] cp, logic [2:0] mods = 3'd0);
        key_in_t k;
        k.flush = 1'b0;
        k.cp    = cp;
        k.mods  = mods;
        pending_keys.insert(pending_keys.size(), k);
    endtask

    task automatic push_flush();
        key_in_t k;
        k.flush = 1'b1;
        k.cp    = 21'($urandom);
        k.mods  = 3'($urandom);
        pending_keys.insert(pending_keys.size(), k);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_cp(21'(s[i]));
    endtask

    task automatic push_number(int unsigned v);
        push_text($sformatf("%0d", v));
    endtask

    function automatic int unsigned rand_param();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 9);
            1:       return $urandom_range(0, 30);
            2:       return $urandom_range(60, 70);
            3:       return $urandom_range(65530, 99999);
            4:       return $urandom_range(195, 205);
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    function automatic logic [20:0] rand_cp();
        case ($urandom_range(0, 6))
            0:       return 21'($urandom_range(0, 31));
            1:       return 21'h7F;
            2:       return 21'($urandom_range(0, 21'h1FFFFF));
            3:       return 21'($urandom_range(21'h10FFF0, 21'h10FFFF));
            default: return 21'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic push_random_sequence();
        string fin;
        int    n;
        case ($urandom_range(0, 11))
            0, 1: push_cp(rand_cp(), 3'($urandom));
            2:
            begin
                push_cp(21'h1B, 3'($urandom));
                if ($urandom_range(0, 1))
                    push_flush();
                else
                    push_cp(rand_cp(), 3'($urandom));
            end
            3:
            begin
                fin = "ABCDHFPQRS";
                push_cp(21'h1B);
                push_cp(21'("O"));
                push_cp($urandom_range(0, 3) == 0 ? rand_cp() : 21'(fin[$urandom_range(0, 9)]));
            end
            4, 5:
            begin
                push_text("\033[");
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        push_cp(21'(";"));
                    if ($urandom_range(0, 4) != 0)
                        push_number(rand_param());
                end
                fin = "~~~ABCDHFPQRSZx";
                push_cp(21'(fin[$urandom_range(0, fin.len() - 1)]));
            end
            6, 7:
            begin
                push_text("\033[<");
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        push_cp(21'(";"));
                    push_number(i == 0 ? $urandom_range(0, 127) : rand_param());
                end
                case ($urandom_range(0, 4))
                    0:       push_cp(rand_cp());
                    1, 2:    push_cp(21'("m"));
                    default: push_cp(21'("M"));
                endcase
            end
            8:
            begin
                push_text("\033[200~");
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_cp(rand_cp(), 3'($urandom));
                if ($urandom_range(0, 3) == 0)
                    push_text("\033[A");
                push_text("\033[201~");
            end
            9: push_flush();
            10:
            begin
                if ($urandom_range(0, 1))
                    push_text("\033[201~");
                else
                    push_text("\033[0201~");
            end
            default:
            begin
                push_cp(21'h1B);
                push_cp(21'("["));
                push_cp(rand_cp());
            end
        endcase
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            tx_gap        <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tx_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (pending_keys.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_keys[0].flush;
                s_axis_tdata  <= {pending_keys[0].mods, pending_keys[0].cp};
                pending_keys.delete(0);
                tx_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // predictor on accepted input and result checker
    always @(posedge clk or negedge rst_n)
    begin
        vted_pkg::result_t exp_ev;
        vted_pkg::result_t got_ev;
        key_in_t acc;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                acc.flush = s_axis_tuser;
                acc.cp    = s_axis_tdata[20:0];
                acc.mods  = s_axis_tdata[23:21];
                if (predict_event(acc, exp_ev))
                    expected_events.insert(expected_events.size(), exp_ev);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_ev.event_kind   = m_axis_tdata[2:0];
                got_ev.key_id       = m_axis_tdata[7:3];
                got_ev.char_out     = m_axis_tdata[28:8];
                got_ev.modifiers    = m_axis_tdata[31:29];
                got_ev.mouse_button = m_axis_tdata[34:32];
                got_ev.mouse_action = m_axis_tdata[36:35];
                got_ev.pos_x        = m_axis_tdata[52:37];
                got_ev.pos_y        = m_axis_tdata[68:53];
                if (expected_events.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("Unexpected result transaction: %h", got_ev);
                end
                else
                begin
                    exp_ev = expected_events[0];
                    expected_events.delete(0);
                    if (got_ev !== exp_ev || m_axis_tdata[71:69] !== 3'd0)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("Mismatch: expected %h, actual %h", exp_ev, got_ev);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_axis_tvalid && m_axis_tready || !m_axis_tready)
            begin
                if (rx_gap > 0)
                begin
                    m_axis_tready <= 1'b0;
                    rx_gap <= rx_gap - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if (m_axis_tvalid && m_axis_tready)
                        rx_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        mismatches = 0;
        stim_done = 0;
        p_mode = vted_pkg::MODE_GROUND;
        p_esc_mods = 3'd0;
        p_paste = 1'b0;
        p_mouse = 1'b0;
        clear_fields();

        // directed: C0 keys, Alt, flush, SS3, CSI keys, tilde, mouse, paste, saturation
        push_cp(21'h0D, 3'd7);
        push_cp(21'h09);
        push_cp(21'h7F, 3'd1);
        push_cp(21'h00);
        push_cp(21'h1C);
        push_cp(21'h1FFFFF, 3'd7);
        push_cp(21'h1B, 3'd5);
        push_flush();
        push_flush();
        push_text("\033x");
        push_text("\033OP");
        push_text("\033[1;6A");
        push_text("\033[24;3~");
        push_text("\033[99~");
        push_text("\033[<0;10;20M");
        push_text("\033[<65;1;0m");
        push_text("\033[<35;0;70000M");
        push_text("\033[<0;5m");
        push_text("\033[<0;5q");
        push_text("\033[200~a");
        push_text("\033[B\033[201~");
        push_text("\033[1;2;3;4;5A");
        push_text("\033[201~");

        while (pending_keys.size() < 750)
            push_random_sequence();
        stim_done = 1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        while ((pending_keys.size() > 0 || s_axis_tvalid || expected_events.size() > 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (errors == 0 && expected_events.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

### filelist.f
hdl/vted_pkg.sv
hdl/vted_decode.sv
hdl/vted_out_skid.sv
hdl/vt_escape_input_decoder_core.sv
hdl/vted_checker.sv
dv/vt_escape_input_decoder_core_tb.sv
